// ----- sv/nearest_row_object_cache_assert.svh -----
// Assertion macros shared by the cache modules. Every macro samples on the
// rising edge of clk and stays quiet while rst_n is low.
`ifndef NEAREST_ROW_OBJECT_CACHE_ASSERT_SVH
`define NEAREST_ROW_OBJECT_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nrc_pkg.sv -----
package nrc_pkg;

  // Field widths of the words on both channels.
  localparam int KIND_W   = 2;
  localparam int ROW_W    = 48;
  localparam int HANDLE_W = 16;

  // Default number of slots.
  localparam int SLOTS_DEF = 7;

  // Operation codes of an input word.
  localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ROW_W-1:0]    row;
    logic [HANDLE_W-1:0] handle;
    logic                in_use;
  } in_word_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle_out;
    logic                stored;
    logic                dropped;
  } out_word_t;

  // One stored slot.
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LAST,
    S_MOVE,
    S_RESP
  } state_t;

  // Which result the datapath records.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_STORED,
    RES_DROPPED,
    RES_FOUND
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_in;
    logic     set_res;
    res_sel_t res_sel;
    logic     do_put;
    logic     do_clear;
    logic     scan_start;
    logic     scan_rd;
    logic     last_rd;
    logic     move;
    logic     load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_use;
    logic              count_zero;
    logic              count_full;
    logic              scan_at_last;
  } dp_stat_t;

endpackage

// ----- sv/nrc_ctrl.sv -----
`include "nearest_row_object_cache_assert.svh"

module nrc_ctrl import nrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The output register can take a word when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESP;
        case (stat.kind)
          KIND_GET: begin
            if (!stat.count_zero) begin
              cmd.set_res    = 1'b0;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          KIND_PUT: begin
            if (!stat.in_use) begin
              if (stat.count_full) begin
                cmd.res_sel = RES_DROPPED;
              end else begin
                cmd.res_sel = RES_STORED;
                cmd.do_put  = 1'b1;
              end
            end
          end
          KIND_CLEAR: begin
            cmd.do_clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_at_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // The last compare finishes while the last slot is read.
        cmd.last_rd = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        cmd.move    = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_FOUND;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  `NRC_ASSERT_NOW(a_scan_nonempty, state_r == S_SCAN, !stat.count_zero, "scan with empty store")
  `NRC_ASSERT_NEXT(a_resp_waits, state_r == S_RESP && !out_free, state_r == S_RESP, "early result")
  `NRC_ASSERT_NEXT(a_take_decode, in_valid && !in_stall, state_r == S_DECODE, "word not decoded")

endmodule

// ----- sv/nrc_dp.sv -----
`include "nearest_row_object_cache_assert.svh"

module nrc_dp import nrc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output out_word_t out_word
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  in_word_t            in_r;
  out_word_t           res_r;
  out_word_t           res_nxt;
  out_word_t           out_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  slot_t               slot_mem_r [SLOTS];
  slot_t               rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  slot_t               wr_data;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [IDX_W-1:0]    scan_idx_nxt;
  logic [IDX_W-1:0]    last_idx;
  logic                cmp_v_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [HANDLE_W-1:0] best_hdl_r;
  logic [ROW_W-1:0]    best_d_r;
  logic                best_any_r;
  logic [ROW_W:0]      diff_up;
  logic [ROW_W:0]      diff_dn;
  logic                at_or_above;
  logic [ROW_W-1:0]    slot_gap;
  logic                take;

  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  // Status toward the controller.
  assign stat.kind         = in_r.kind;
  assign stat.in_use       = in_r.in_use;
  assign stat.count_zero   = (count_r == '0);
  assign stat.count_full   = (count_r == CNT_W'(SLOTS));
  assign stat.scan_at_last = (scan_idx_r == last_idx);

  assign out_word = out_r;

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_word;
    end
  end

  // Slot count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
    end else if (cmd.do_put) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.move) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cmp_v_r <= cmd.scan_rd;
    end
  end

  // Slot memory: one write port, one registered read port.
  assign rd_addr = cmd.scan_rd ? scan_idx_r : last_idx;
  assign wr_en   = cmd.do_put || cmd.move;
  assign wr_addr = cmd.do_put ? count_r[IDX_W-1:0] : best_idx_r;
  always_comb begin
    if (cmd.do_put) begin
      wr_data.row    = in_r.row;
      wr_data.handle = in_r.handle;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem_r[rd_addr];
  end

  // Scan address counter.
  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (cmd.scan_start) begin
      scan_idx_nxt = '0;
    end else if (cmd.scan_rd) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    if (cmd.scan_rd) begin
      cmp_idx_r <= scan_idx_r;
    end
  end

  // Distance of the slot just read. A slot at or above the row wins ties;
  // a slot below needs a strictly smaller distance.
  assign diff_up     = {1'b0, rd_data_r.row} - {1'b0, in_r.row};
  assign diff_dn     = {1'b0, in_r.row} - {1'b0, rd_data_r.row};
  assign at_or_above = !diff_up[ROW_W];
  assign slot_gap    = at_or_above ? diff_up[ROW_W-1:0] : diff_dn[ROW_W-1:0];
  assign take        = !best_any_r ||
                       (at_or_above ? (slot_gap <= best_d_r) : (slot_gap < best_d_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_any_r <= 1'b0;
    end else if (cmp_v_r && take) begin
      best_any_r <= 1'b1;
      best_idx_r <= cmp_idx_r;
      best_hdl_r <= rd_data_r.handle;
      best_d_r   <= slot_gap;
    end
  end

  // Result word.
  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      RES_STORED:  res_nxt.stored  = 1'b1;
      RES_DROPPED: res_nxt.dropped = 1'b1;
      RES_FOUND: begin
        res_nxt.found      = 1'b1;
        res_nxt.handle_out = best_hdl_r;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_r <= res_nxt;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  `NRC_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(SLOTS), "slot count above capacity")
  `NRC_ASSERT_NOW(a_put_room, cmd.do_put, count_r < CNT_W'(SLOTS), "put into full store")
  `NRC_ASSERT_NOW(a_move_scan, cmd.move, $past(cmd.last_rd) && best_any_r, "move before scan end")

endmodule

// ----- sv/nearest_row_object_cache.sv -----
// Nearest-row object cache.
// Input channel in_valid / in_stall / in_word carries one operation per word:
// get nearest, put object, or clear all slots. The output channel
// out_valid / out_stall / out_word returns exactly one result word for each
// input word, in order. The block holds at most SLOTS pairs of row and handle.
// A word is taken only when the block is idle, so in_stall is high from the
// accepted word until its result has been loaded into the output register.
// Put, clear and a get on an empty store go from the decode state straight to
// the response state. A get on n stored slots reads them one per cycle through
// the single read port of the slot memory, then passes through the last and
// move states before the response state.
// The output register holds its word while out_stall is high; a new word can
// still be worked on, and its result waits until the register is free.
// Reset (rst_n low, synchronous) empties the store and clears both valid flags;
// slot contents are not cleared, since only slots below the count are read.
module nearest_row_object_cache import nrc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  nrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot storage, nearest-row search and result registers.
  nrc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
